### src/base64_stream_decoder_macros.svh
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH
`ifndef SYNTH
`define B64D_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64d assertion failed");
`define B64D_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT_IMP(label, clk, rstn, ante, cons)
`define B64D_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/b64d_pkg.sv
// shared types, constants and character map of the base64 stream decoder
`default_nettype none
package b64d_pkg;

    localparam int MAX_OUT_BYTES = 4096;
    localparam int CAP_W = 13;
    localparam int CNT_W = $clog2(MAX_OUT_BYTES + 1);
    localparam int CMP_W = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    localparam logic [7:0] SX_LOWER_BASE = 8'd26;
    localparam logic [7:0] SX_DIGIT_BASE = 8'd52;
    localparam logic [5:0] SX_PLUS = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;

    typedef enum logic [1:0] {
        FUNC_CHAR  = 2'd0,
        FUNC_FINAL = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_LONE     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ZERO_CAP = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CH_SEXTET,
        CH_SKIP,
        CH_PAD,
        CH_BAD
    } char_kind_t;

    typedef enum logic {
        REG_URL_MODE = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_idx_t;

    typedef struct packed {
        char_kind_t kind;
        logic [5:0] sextet;
    } char_map_t;

    typedef struct packed {
        logic             url_mode;
        logic [CAP_W-1:0] out_capacity;
    } cfg_t;

    typedef struct packed {
        logic [2:0][7:0]  bytes;
        logic [1:0]       nbytes;
        logic             done;
        status_t          status;
        logic [CAP_W-1:0] length;
    } bundle_t;

    function automatic char_map_t b64d_map_char(input logic [7:0] c, input logic url);
        char_map_t m;
        m.kind = CH_BAD;
        m.sextet = '0;
        priority if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            m.kind = CH_SKIP;
        end else if (c == 8'h3D) begin
            m.kind = CH_PAD;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            m.kind = CH_SEXTET;
            m.sextet = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            m.kind = CH_SEXTET;
            m.sextet = 6'(c - 8'h61 + SX_LOWER_BASE);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            m.kind = CH_SEXTET;
            m.sextet = 6'(c - 8'h30 + SX_DIGIT_BASE);
        end else if (c == 8'h2B || (url && c == 8'h2D)) begin
            m.kind = CH_SEXTET;
            m.sextet = SX_PLUS;
        end else if (c == 8'h2F || (url && c == 8'h5F)) begin
            m.kind = CH_SEXTET;
            m.sextet = SX_SLASH;
        end else begin
            m.kind = CH_BAD;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

### src/b64d_regs.sv
// configuration registers behind the apb port
`default_nettype none
module b64d_regs
    import b64d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic             url_mode_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic             wr_en;
    reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_mode_reg <= 1'b0;
            capacity_reg <= CAP_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_URL_MODE: url_mode_reg <= pwdata[0];
                REG_CAPACITY: capacity_reg <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_URL_MODE: prdata = {31'b0, url_mode_reg};
            REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, capacity_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.url_mode     = url_mode_reg;
    assign cfg.out_capacity = capacity_reg;

endmodule
`default_nettype wire

### src/b64d_core.sv
// input register, decode state and per-character decode logic
`default_nettype none
module b64d_core
    import b64d_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [7:0] s_char_code,
    output logic            bundle_push,
    input  wire logic       bundle_ready,
    output bundle_t         bundle
);

    logic             in_valid_reg;
    logic [1:0]       func_reg;
    logic [7:0]       char_reg;

    logic [2:0][5:0]  hold_reg, hold_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pad_reg, pad_next;
    status_t          err_reg, err_next;
    logic [CNT_W-1:0] bc_reg, bc_next;

    char_map_t        map;
    logic             do_take;
    logic             do_finish;
    logic [1:0]       nb;
    logic [5:0]       s3;
    logic [CMP_W-1:0] cap;
    logic [CMP_W-1:0] cap_cfg;
    logic [CMP_W-1:0] sum;
    logic             nonempty;
    logic             consume;
    status_t          st;

    assign consume     = in_valid_reg && (!nonempty || bundle_ready);
    assign s_ready     = !in_valid_reg || consume;
    assign bundle_push = consume && nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
        end
    end

    always_comb begin
        map       = b64d_map_char(char_reg, cfg.url_mode);
        do_take   = (func_reg == FUNC_CHAR) || (func_reg == FUNC_FINAL);
        do_finish = (func_reg == FUNC_FINAL) || (func_reg == FUNC_END);
        cap_cfg   = CMP_W'(cfg.out_capacity);
        cap       = (cap_cfg > CMP_W'(MAX_OUT_BYTES)) ? CMP_W'(MAX_OUT_BYTES) : cap_cfg;

        hold_next = hold_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        bc_next   = bc_reg;
        nb        = 2'd0;
        s3        = 6'd0;

        if (do_take && err_reg == ST_OK && !pad_reg) begin
            unique case (map.kind)
                CH_SKIP: ;
                CH_PAD:  pad_next = 1'b1;
                CH_BAD:  err_next = ST_BAD_CHAR;
                default: begin
                    unique case (cnt_reg)
                        2'd0: begin
                            hold_next[0] = map.sextet;
                            cnt_next = 2'd1;
                        end
                        2'd1: begin
                            hold_next[1] = map.sextet;
                            cnt_next = 2'd2;
                        end
                        2'd2: begin
                            hold_next[2] = map.sextet;
                            cnt_next = 2'd3;
                        end
                        default: begin
                            cnt_next = 2'd0;
                            nb = 2'd3;
                            s3 = map.sextet;
                        end
                    endcase
                end
            endcase
        end

        if (do_finish && err_next == ST_OK) begin
            unique case (cnt_next)
                2'd1:    err_next = ST_LONE;
                2'd2:    nb = 2'd1;
                2'd3:    nb = 2'd2;
                default: ;
            endcase
        end

        sum = CMP_W'(bc_reg) + CMP_W'(nb);
        if (nb != 2'd0) begin
            if (sum > cap) begin
                err_next = ST_OVERFLOW;
                nb = 2'd0;
            end else begin
                bc_next = CNT_W'(sum);
            end
        end

        st = err_next;
        if (do_finish && cfg.url_mode && cfg.out_capacity == '0) begin
            st = ST_ZERO_CAP;
        end

        bundle.bytes[0] = {hold_next[0], hold_next[1][5:4]};
        bundle.bytes[1] = {hold_next[1][3:0], hold_next[2][5:2]};
        bundle.bytes[2] = {hold_next[2][1:0], s3};
        bundle.nbytes   = nb;
        bundle.done     = do_finish;
        bundle.status   = st;
        bundle.length   = (st == ST_OK) ? CAP_W'(bc_next) : '0;
        nonempty        = (nb != 2'd0) || do_finish;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 1'b0;
            err_reg  <= ST_OK;
            bc_reg   <= '0;
        end else if (consume) begin
            if (do_finish) begin
                hold_reg <= '0;
                cnt_reg  <= 2'd0;
                pad_reg  <= 1'b0;
                err_reg  <= ST_OK;
                bc_reg   <= '0;
            end else begin
                hold_reg <= hold_next;
                cnt_reg  <= cnt_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
                bc_reg   <= bc_next;
            end
        end
    end

endmodule
`default_nettype wire

### src/b64d_serial.sv
// result register that sends one bundle as a run of result transactions
`default_nettype none
module b64d_serial
    import b64d_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    bundle_push,
    output logic         bundle_ready,
    input  wire bundle_t bundle,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_byte_valid,
    output logic         m_done_res,
    output logic [2:0]   m_status,
    output logic [12:0]  m_out_length,
    output logic         m_last
);

    logic       valid_reg;
    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       byte_phase;
    logic       fire;
    logic [7:0] cur_byte;

    assign byte_phase   = idx_reg < bundle_reg.nbytes;
    assign fire         = m_valid && m_ready;
    assign bundle_ready = !valid_reg || (fire && m_last);

    always_comb begin
        unique case (idx_reg)
            2'd0:    cur_byte = bundle_reg.bytes[0];
            2'd1:    cur_byte = bundle_reg.bytes[1];
            2'd2:    cur_byte = bundle_reg.bytes[2];
            default: cur_byte = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (bundle_ready) begin
            valid_reg <= bundle_push;
            idx_reg   <= 2'd0;
        end else if (fire) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_ready && bundle_push) begin
            bundle_reg <= bundle;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_phase ? cur_byte : 8'd0;
    assign m_byte_valid = byte_phase;
    assign m_done_res   = !byte_phase;
    assign m_status     = byte_phase ? ST_OK : bundle_reg.status;
    assign m_out_length = byte_phase ? 13'd0 : 13'(bundle_reg.length);
    assign m_last       = byte_phase
                          ? ((idx_reg == bundle_reg.nbytes - 2'd1) && !bundle_reg.done)
                          : 1'b1;

endmodule
`default_nettype wire

### src/base64_stream_decoder.sv
// base64 stream decoder top level
//
// Decodes standard or base64url text, one character per input transaction
// (s_func, s_char_code), into bytes on the result channel (m_*). A text ends
// with a final character or an end-of-text transaction and gives one closing
// done transaction with status and byte count. Registers at byte address 0
// (url_mode) and 4 (out_capacity) are to be written over the apb port only
// while idle; the block does not enforce this. A character is decoded
// while it sits in the input register; its first result moves into the
// result register once that register is free, and is driven on the port.
// One character is taken per cycle while m_ready is high; a completed group
// holds the result register for its three byte transactions, which the next
// three characters overlap, so plain text flows at one character per cycle.
// A closing character can give up to four result transactions.
// Reset clears the registers to url_mode 0, out_capacity 4096, and empties
// the decode state and both registers. While m_ready is low the result
// register holds, then the input register fills and s_ready drops.
`default_nettype none
`include "base64_stream_decoder_macros.svh"
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_char_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_done_res,
    output logic [2:0]       m_status,
    output logic [12:0]      m_out_length,
    output logic             m_last
);

    cfg_t    cfg;
    bundle_t bundle;
    logic    bundle_push;
    logic    bundle_ready;

    b64d_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    b64d_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_char_code  (s_char_code),
        .bundle_push  (bundle_push),
        .bundle_ready (bundle_ready),
        .bundle       (bundle)
    );

    b64d_serial u_serial (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bundle_push  (bundle_push),
        .bundle_ready (bundle_ready),
        .bundle       (bundle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .m_out_length (m_out_length),
        .m_last       (m_last)
    );

    // a bundle only moves into a free result register
    `B64D_ASSERT_IMP(a_push_into_free, aclk, aresetn, bundle_push, bundle_ready)
    // the done transaction always closes the run
    `B64D_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_valid && m_done_res, m_last)
    // a run continues after a transaction that is not its last
    `B64D_ASSERT_NXT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)

endmodule
`default_nettype wire
